/* rtl/core/rgbhsv_pkg.sv */
`timescale 1ns / 1ps

package rgbhsv_pkg;

  // Channel and result widths
  localparam int CH_W   = 8;
  localparam int HUE_W  = 9;
  localparam int PCT_W  = 7;

  // Numerator widths: hue numerator tops out at 420 * 255, percent at 100 * 255
  localparam int HNUM_W = 17;
  localparam int PNUM_W = 15;

  // Reciprocal format: floor(2^RECIP_SHIFT / d), d = 1 needs one bit more
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int HPROD_W     = HNUM_W + RECIP_W;
  localparam int PPROD_W     = PNUM_W + RECIP_W;

  // Colour constants
  localparam logic [CH_W-1:0]   CH_FULL    = 8'd255;
  localparam logic [HNUM_W-1:0] HUE_SCALE  = 17'd60;
  localparam logic [HNUM_W-1:0] OFS_RED    = 17'd360;
  localparam logic [HNUM_W-1:0] OFS_GREEN  = 17'd120;
  localparam logic [HNUM_W-1:0] OFS_BLUE   = 17'd240;
  localparam logic [HUE_W-1:0]  HUE_WRAP   = 9'd360;
  localparam logic [PNUM_W-1:0] PCT_SCALE  = 15'd100;

  localparam logic [RECIP_W-1:0] FULL_RECIP = RECIP_W'((1 << RECIP_SHIFT) / 255);

endpackage

/* rtl/core/rgb_to_hsv_converter_top.sv */
`timescale 1ns / 1ps
// RGB to HSV conversion: hue in degrees, saturation and brightness in percent.
// One pixel per clock unless the result channel stalls; four register stages, each with
// its own valid bit. The three quotients use one multiplier each: hue and saturation by
// the reciprocal table, brightness by a constant reciprocal, with a single remainder
// correction step. Reset (synchronous) clears the valid bits only.
module rgb_to_hsv_converter_top
  import rgbhsv_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // pixel channel
  input  logic              pixel_valid,
  output logic              pixel_stall,
  input  logic [CH_W-1:0]   red,
  input  logic [CH_W-1:0]   green,
  input  logic [CH_W-1:0]   blue,
  // result channel
  output logic              hsv_valid,
  input  logic              hsv_stall,
  output logic [HUE_W-1:0]  hue,
  output logic [PCT_W-1:0]  saturation,
  output logic [PCT_W-1:0]  brightness
);

  // ---------------------------------------------------------------------------
  // Reciprocal table: floor(2^RECIP_SHIFT / d) for d = 1..255, zero for d = 0.
  // A zero divisor only occurs for grey or black pixels, whose results are
  // forced to zero further down.
  // ---------------------------------------------------------------------------
  logic [RECIP_W-1:0] recip_tab [2**CH_W];

  for (genvar i = 0; i < 2**CH_W; i++) begin : g_recip
    localparam logic [RECIP_W-1:0] RVAL =
      (i == 0) ? '0 : RECIP_W'((1 << RECIP_SHIFT) / ((i == 0) ? 1 : i));
    assign recip_tab[i] = RVAL;
  end

  // ---------------------------------------------------------------------------
  // Flow control: a stage may load when it is empty or its contents move on.
  // The output register is the last stage, so a pixel can still be taken while a
  // finished result waits for its transfer, as long as some stage is empty.
  // ---------------------------------------------------------------------------
  logic v1, v2, v3, v4;
  logic ready1, ready2, ready3, ready4;

  assign ready4      = !v4 || !hsv_stall;
  assign ready3      = !v3 || ready4;
  assign ready2      = !v2 || ready3;
  assign ready1      = !v1 || ready2;
  assign pixel_stall = !ready1;
  assign hsv_valid   = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (ready1) v1 <= pixel_valid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
      if (ready4) v4 <= v3;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: capture the pixel.
  // ---------------------------------------------------------------------------
  logic [CH_W-1:0] r1, g1, b1;

  always_ff @(posedge clk) begin
    if (ready1 && pixel_valid) begin
      r1 <= red;
      g1 <= green;
      b1 <= blue;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: max, min, chroma and the three numerators.
  // The sector goes to the first channel equal to max: red, then green, then
  // blue. Each hue numerator is 60 * difference + offset * chroma; it never
  // goes negative, so modular unsigned arithmetic gives it exactly.
  // ---------------------------------------------------------------------------
  logic [CH_W-1:0]   mx_c, mn_c, chroma_c;
  logic [HNUM_W-1:0] hnum_c;
  logic              red_sec_c;

  always_comb begin
    mx_c = r1;
    if (g1 > mx_c) mx_c = g1;
    if (b1 > mx_c) mx_c = b1;
    mn_c = r1;
    if (g1 < mn_c) mn_c = g1;
    if (b1 < mn_c) mn_c = b1;
    chroma_c  = mx_c - mn_c;
    red_sec_c = (mx_c == r1);
    if (mx_c == r1) begin
      hnum_c = HUE_SCALE * HNUM_W'(g1) - HUE_SCALE * HNUM_W'(b1)
             + OFS_RED * HNUM_W'(chroma_c);
    end else if (mx_c == g1) begin
      hnum_c = HUE_SCALE * HNUM_W'(b1) - HUE_SCALE * HNUM_W'(r1)
             + OFS_GREEN * HNUM_W'(chroma_c);
    end else begin
      hnum_c = HUE_SCALE * HNUM_W'(r1) - HUE_SCALE * HNUM_W'(g1)
             + OFS_BLUE * HNUM_W'(chroma_c);
    end
  end

  logic [HNUM_W-1:0] hnum2;
  logic [PNUM_W-1:0] snum2, vnum2;
  logic [CH_W-1:0]   c2, mx2;
  logic              red2;

  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      hnum2 <= hnum_c;
      snum2 <= PCT_SCALE * PNUM_W'(chroma_c);
      vnum2 <= PCT_SCALE * PNUM_W'(mx_c);
      c2    <= chroma_c;
      mx2   <= mx_c;
      red2  <= red_sec_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: quotient estimates by reciprocal multiplication.
  // Each estimate is the true quotient or one less.
  // ---------------------------------------------------------------------------
  logic [HPROD_W-1:0] hprod_c;
  logic [PPROD_W-1:0] sprod_c, vprod_c;

  assign hprod_c = HPROD_W'(hnum2) * HPROD_W'(recip_tab[c2]);
  assign sprod_c = PPROD_W'(snum2) * PPROD_W'(recip_tab[mx2]);
  assign vprod_c = PPROD_W'(vnum2) * PPROD_W'(FULL_RECIP);

  logic [HUE_W-1:0]  hq3;
  logic [PCT_W-1:0]  sq3, vq3;
  logic [HNUM_W-1:0] hnum3;
  logic [PNUM_W-1:0] snum3, vnum3;
  logic [CH_W-1:0]   c3, mx3;
  logic              red3;

  always_ff @(posedge clk) begin
    if (ready3 && v2) begin
      hq3   <= hprod_c[RECIP_SHIFT +: HUE_W];
      sq3   <= sprod_c[RECIP_SHIFT +: PCT_W];
      vq3   <= vprod_c[RECIP_SHIFT +: PCT_W];
      hnum3 <= hnum2;
      snum3 <= snum2;
      vnum3 <= vnum2;
      c3    <= c2;
      mx3   <= mx2;
      red3  <= red2;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: remainder correction, hue wrap and the grey / black cases.
  // Only the red sector can reach 360 degrees or more.
  // ---------------------------------------------------------------------------
  logic [HNUM_W-1:0] hrem_c;
  logic [PNUM_W-1:0] srem_c, vrem_c;
  logic [HUE_W-1:0]  hfix_c, hue_c;
  logic [PCT_W-1:0]  sfix_c, vfix_c;

  always_comb begin
    hrem_c = hnum3 - HNUM_W'(hq3) * HNUM_W'(c3);
    srem_c = snum3 - PNUM_W'(sq3) * PNUM_W'(mx3);
    vrem_c = vnum3 - PNUM_W'(vq3) * PNUM_W'(CH_FULL);
    hfix_c = hq3 + HUE_W'(hrem_c >= HNUM_W'(c3));
    sfix_c = sq3 + PCT_W'(srem_c >= PNUM_W'(mx3));
    vfix_c = vq3 + PCT_W'(vrem_c >= PNUM_W'(CH_FULL));
    hue_c  = hfix_c;
    if (red3 && (hfix_c >= HUE_WRAP)) hue_c = hfix_c - HUE_WRAP;
    // grey pixel: no hue
    if (c3 == '0) hue_c = '0;
    // black pixel: no saturation
    if (mx3 == '0) sfix_c = '0;
  end

  always_ff @(posedge clk) begin
    if (ready4 && v3) begin
      hue        <= hue_c;
      saturation <= sfix_c;
      brightness <= vfix_c;
    end
  end

endmodule

/* verif/tb_rgb_to_hsv_converter_top.sv */
`timescale 1ns / 1ps

module tb_rgb_to_hsv_converter_top;
  import rgbhsv_pkg::*;

  // Cycles without any transfer before the run is declared hung
  localparam int STALL_LIMIT  = 2000;
  // Length of the long receiver hold-off that backs the pipeline up
  localparam int HOLD_CYCLES  = 300;
  // Cycles to wait after the last result for anything spurious
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_PER_PHASE = 345;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] sat;
    logic [PCT_W-1:0] bright;
  } hsv_t;

  // Which channel decides the hue; ties resolve red first, then green
  typedef enum logic [1:0] {SECTOR_RED, SECTOR_GREEN, SECTOR_BLUE} hue_sector_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             pixel_valid = 1'b0;
  logic             pixel_stall;
  logic [CH_W-1:0]  red = '0;
  logic [CH_W-1:0]  green = '0;
  logic [CH_W-1:0]  blue = '0;
  logic             hsv_valid;
  logic             hsv_stall = 1'b0;
  logic [HUE_W-1:0] hue;
  logic [PCT_W-1:0] saturation;
  logic [PCT_W-1:0] brightness;

  pixel_t pixel_q[$];       // pixels waiting to be offered
  hsv_t   hsv_expect_q[$];  // colours owed by the block, oldest first

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holds_asked   = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int idle_cycles   = 0;
  int mismatches    = 0;

  rgb_to_hsv_converter_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .hsv_valid  (hsv_valid),
    .hsv_stall  (hsv_stall),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness)
  );

  always #5 clk = ~clk;

  // Exact integer HSV of one pixel; every quotient rounds down.
  function automatic hsv_t hsv_of(pixel_t px);
    int r, g, b, top, bottom, chroma, numer;
    hue_sector_t sector;
    hsv_t res;
    r = px.r;
    g = px.g;
    b = px.b;
    top = r;
    if (g > top) top = g;
    if (b > top) top = b;
    bottom = r;
    if (g < bottom) bottom = g;
    if (b < bottom) bottom = b;
    chroma = top - bottom;
    if (r == top) sector = SECTOR_RED;
    else if (g == top) sector = SECTOR_GREEN;
    else sector = SECTOR_BLUE;
    case (sector)
      SECTOR_RED:   numer = 60 * (g - b) + 360 * chroma;
      SECTOR_GREEN: numer = 60 * (b - r) + 120 * chroma;
      default:      numer = 60 * (r - g) + 240 * chroma;
    endcase
    // A grey pixel has no hue; a black one has no saturation
    res.hue    = (chroma == 0) ? '0 : HUE_W'((numer / chroma) % 360);
    res.sat    = (top == 0) ? '0 : PCT_W'((100 * chroma) / top);
    res.bright = PCT_W'((100 * top) / 255);
    return res;
  endfunction

  // One of 0, 1, 254, 255
  function automatic logic [CH_W-1:0] edge_level();
    logic [1:0] pick;
    pick = 2'($urandom_range(0, 3));
    return pick[1] ? CH_FULL - CH_W'(pick[0]) : CH_W'(pick[0]);
  endfunction

  // Random pixel, biased towards greys, ties and near-greys where the
  // sector choice and the small-chroma divisions are most fragile
  function automatic pixel_t random_pixel();
    pixel_t px;
    logic [CH_W-1:0] base;
    base = CH_W'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0: px = '{base, base, base};
      1: begin
        px = '{base, base, base};
        case ($urandom_range(0, 2))
          0: px.r = CH_W'($urandom_range(0, base));
          1: px.g = CH_W'($urandom_range(0, base));
          default: px.b = CH_W'($urandom_range(0, base));
        endcase
      end
      2: begin
        base = CH_W'($urandom_range(0, 252));
        px = '{base + CH_W'($urandom_range(0, 3)), base + CH_W'($urandom_range(0, 3)),
               base + CH_W'($urandom_range(0, 3))};
      end
      3: px = '{edge_level(), edge_level(), edge_level()};
      default: px = pixel_t'($urandom);
    endcase
    return px;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Pixel driver: record each transfer, then refill the slot from the queue
  always @(posedge clk) begin : drive_pixels
    pixel_t nxt;
    if (rst) begin
      pixel_valid <= 1'b0;
    end else begin
      if (pixel_valid && !pixel_stall) begin
        hsv_expect_q.push_back(hsv_of('{red, green, blue}));
      end
      // Hold the payload while stalled; otherwise offer the next pixel or idle
      if (!pixel_valid || !pixel_stall) begin
        if (pixel_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pixel_q.pop_front();
          pixel_valid <= 1'b1;
          red         <= nxt.r;
          green       <= nxt.g;
          blue        <= nxt.b;
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random stalls, plus a long hold-off whenever one is asked for
  always @(posedge clk) begin
    if (rst) begin
      hsv_stall <= 1'b0;
      hold_left <= 0;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_asked;
      hold_left    <= HOLD_CYCLES;
      hsv_stall    <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      hsv_stall <= 1'b1;
    end else begin
      hsv_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Monitor: compare every result transfer with the oldest owed colour
  always @(posedge clk) begin : check_results
    hsv_t want;
    if (!rst && hsv_valid && !hsv_stall) begin
      if (hsv_expect_q.size() == 0) begin
        report_mismatch("unexpected result, hue", hue, 0);
      end else begin
        want = hsv_expect_q.pop_front();
        if (hue !== want.hue) report_mismatch("hue", hue, want.hue);
        if (saturation !== want.sat) report_mismatch("saturation", saturation, want.sat);
        if (brightness !== want.bright) report_mismatch("brightness", brightness, want.bright);
      end
    end
  end

  // Watchdog: give up when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (hsv_valid && !hsv_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int send_pct[3];
    int recv_pct[3];
    send_pct = '{28, 69, 0};
    recv_pct = '{69, 28, 0};

    // Directed pixels: black, white, greys, primaries, ties between maxima,
    // hue just below the wrap, tiny chroma and the darkest saturated pixels
    pixel_q.push_back('{8'd0,   8'd0,   8'd0});
    pixel_q.push_back('{8'd255, 8'd255, 8'd255});
    pixel_q.push_back('{8'd128, 8'd128, 8'd128});
    pixel_q.push_back('{8'd255, 8'd0,   8'd0});
    pixel_q.push_back('{8'd0,   8'd255, 8'd0});
    pixel_q.push_back('{8'd0,   8'd0,   8'd255});
    pixel_q.push_back('{8'd255, 8'd255, 8'd0});
    pixel_q.push_back('{8'd0,   8'd255, 8'd255});
    pixel_q.push_back('{8'd255, 8'd0,   8'd255});
    pixel_q.push_back('{8'd255, 8'd0,   8'd1});
    pixel_q.push_back('{8'd255, 8'd1,   8'd0});
    pixel_q.push_back('{8'd1,   8'd0,   8'd0});
    pixel_q.push_back('{8'd0,   8'd1,   8'd0});
    pixel_q.push_back('{8'd0,   8'd0,   8'd1});
    pixel_q.push_back('{8'd1,   8'd1,   8'd0});
    pixel_q.push_back('{8'd254, 8'd255, 8'd253});
    pixel_q.push_back('{8'd255, 8'd254, 8'd0});
    pixel_q.push_back('{8'd200, 8'd100, 8'd50});
    pixel_q.push_back('{8'd50,  8'd100, 8'd200});
    pixel_q.push_back('{8'd100, 8'd200, 8'd50});
    pixel_q.push_back('{8'd10,  8'd0,   8'd255});
    pixel_q.push_back('{8'd170, 8'd85,  8'd170});

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 3; phase++) begin
      // Change queues and rates only between edges, away from the clocked blocks
      @(negedge clk);
      send_idle_pct = send_pct[phase];
      recv_idle_pct = recv_pct[phase];
      for (int i = 0; i < RANDOM_PER_PHASE; i++) pixel_q.push_back(random_pixel());
      // With the sender flat out, hold the receiver off so the pipe fills and stalls
      if (phase == 2) holds_asked++;
      while (pixel_q.size() != 0 || pixel_valid || hsv_expect_q.size() != 0) begin
        @(negedge clk);
      end
    end

    // Leave time for any stray result to show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* rgb_to_hsv_converter_top.f */
rtl/core/rgbhsv_pkg.sv
rtl/core/rgb_to_hsv_converter_top.sv
verif/tb_rgb_to_hsv_converter_top.sv
